[hdl/largest_square_of_ones_defines.svh]
// Assertion macros shared by the largest-square block.
`ifndef LARGEST_SQUARE_OF_ONES_DEFINES_SVH
`define LARGEST_SQUARE_OF_ONES_DEFINES_SVH

// Checked on every rising edge while reset is released.
`define LSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge that follows an edge with reset asserted.
`define LSQ_ASSERT_AFTER_RESET(label, prop, msg) \
  label: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

[hdl/lsq_pkg.sv]
// Shared constants, types and helpers for the largest-square block.
package lsq_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CFG_W  = 11;
  localparam int SIDE_W = 11;
  localparam int AREA_W = 21;
  localparam int IDX_W  = 2;
  localparam int IN_W   = 8;
  localparam int OUT_W  = SIDE_W + AREA_W;

  localparam logic [IDX_W-1:0] CFG_COLUMNS_USED = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_ROWS_USED    = IDX_W'(1);

  // One finished frame handed from the cell core to the result stages.
  typedef struct packed {
    logic              valid;
    logic [SIDE_W-1:0] side;
  } frame_res_t;

  // A zero count acts as one, a count above the maximum acts as the maximum.
  function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hdl/lsq_line_store.sv]
// Line store holding the previous row's square sides, with a clearing pass after reset.
module lsq_line_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [lsq_pkg::COL_W-1:0]  wr_addr,
  input  logic [lsq_pkg::SIDE_W-1:0] wr_data,
  input  logic [lsq_pkg::COL_W-1:0]  rd_addr,
  output logic [lsq_pkg::SIDE_W-1:0] rd_data,
  output logic                       busy
);
  import lsq_pkg::*;

  logic [SIDE_W-1:0] mem [MAX_COLUMNS];
  logic [SIDE_W-1:0] rd_data_r;
  logic              clearing_r;
  logic [COL_W-1:0]  clr_addr_r;

  logic              we;
  logic [COL_W-1:0]  waddr;
  logic [SIDE_W-1:0] wdata;

  always_comb begin
    we    = clearing_r ? 1'b1 : wr_en;
    waddr = clearing_r ? clr_addr_r : wr_addr;
    wdata = clearing_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_COLUMNS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the address written in the same cycle returns the new value.
  always_ff @(posedge clk) begin
    if (we && (waddr == rd_addr)) begin
      rd_data_r <= wdata;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

[hdl/lsq_cell_core.sv]
// Raster counters, configuration registers and the per-cell square-side update.
module lsq_cell_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lsq_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lsq_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       cell_bit,
  input  logic                       res_ready,
  input  logic                       store_busy,
  input  logic [lsq_pkg::SIDE_W-1:0] up_raw,
  output logic                       wr_en,
  output logic [lsq_pkg::COL_W-1:0]  wr_addr,
  output logic [lsq_pkg::SIDE_W-1:0] wr_data,
  output logic [lsq_pkg::COL_W-1:0]  rd_addr,
  output lsq_pkg::frame_res_t        frame_res
);
  import lsq_pkg::*;

  logic [COL_W-1:0]  cols_last_r;
  logic [ROW_W-1:0]  rows_last_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SIDE_W-1:0] left_r, left_nxt;
  logic [SIDE_W-1:0] diag_r, diag_nxt;
  logic [SIDE_W-1:0] largest_r, largest_nxt;

  logic              accept;
  logic              first_row, first_col, row_end, frame_end;
  logic [SIDE_W-1:0] up, diag, left, m, side, best;

  assign cfg_ready = 1'b1;
  assign in_tready = res_ready && !store_busy;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= COL_W'(MAX_COLUMNS - 1);
      rows_last_r <= ROW_W'(MAX_ROWS - 1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMNS_USED: cols_last_r <=
          COL_W'(clamp_count(cfg_data, CFG_W'(MAX_COLUMNS)) - CFG_W'(1));
        CFG_ROWS_USED: rows_last_r <=
          ROW_W'(clamp_count(cfg_data, CFG_W'(MAX_ROWS)) - CFG_W'(1));
        default: ;
      endcase
    end
  end

  always_comb begin
    first_row = (row_r == '0);
    first_col = (col_r == '0);
    up        = first_row ? '0 : up_raw;
    diag      = (first_row || first_col) ? '0 : diag_r;
    left      = first_col ? '0 : left_r;
    m         = (up < diag) ? up : diag;
    m         = (m < left) ? m : left;
    side      = cell_bit ? (m + SIDE_W'(1)) : '0;
    best      = (side > largest_r) ? side : largest_r;
    // Comparing with >= ends the row even if a smaller count was written mid-frame.
    row_end   = (col_r >= cols_last_r);
    frame_end = row_end && (row_r >= rows_last_r);
  end

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    left_nxt    = left_r;
    diag_nxt    = diag_r;
    largest_nxt = largest_r;
    if (accept) begin
      left_nxt    = side;
      diag_nxt    = up;
      largest_nxt = frame_end ? '0 : best;
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      left_r    <= '0;
      diag_r    <= '0;
      largest_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      left_r    <= left_nxt;
      diag_r    <= diag_nxt;
      largest_r <= largest_nxt;
    end
  end

  // The store is read one beat ahead so that the up neighbor waits in its output register.
  assign rd_addr = col_nxt;
  assign wr_en   = accept;
  assign wr_addr = col_r;
  assign wr_data = side;

  assign frame_res.valid = accept && frame_end;
  assign frame_res.side  = best;

endmodule

[hdl/lsq_result.sv]
// Two result stages: a holding stage for the frame's best side, then the squared area.
module lsq_result (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lsq_pkg::frame_res_t       frame_res,
  output logic                      res_ready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [lsq_pkg::OUT_W-1:0] out_tdata
);
  import lsq_pkg::*;

  logic              a_valid_r;
  logic [SIDE_W-1:0] a_side_r;
  logic              b_valid_r;
  logic [SIDE_W-1:0] b_side_r;
  logic [AREA_W-1:0] b_area_r;
  logic              b_ready;
  logic [2*SIDE_W-1:0] square;

  assign b_ready   = !b_valid_r || out_tready;
  assign res_ready = !a_valid_r || b_ready;
  assign square    = a_side_r * a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        a_valid_r <= frame_res.valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && frame_res.valid) begin
      a_side_r <= frame_res.side;
    end
    if (b_ready && a_valid_r) begin
      b_side_r <= a_side_r;
      b_area_r <= square[AREA_W-1:0];
    end
  end

  assign out_tvalid = b_valid_r;
  assign out_tdata  = {b_area_r, b_side_r};

endmodule

[hdl/largest_square_of_ones.sv]
// Top level of the streaming largest all-ones square detector.
//
// Grid cells enter on the in_ channel, one bit per beat in raster order, row by row.
// A beat can be taken in every cycle while in_tready is high. After the last cell of
// a frame, as set by the columns_used and rows_used registers, one result beat leaves
// on the out_ channel with the frame's best square side and its area. Cells that end
// no frame give none. The result passes one holding stage, then the stage that
// squares the side with a single 11 by 11 multiplier. Throughput is one cell per
// cycle while in_tready is high, set by the line store with one read and one write
// port that is read one beat ahead and written by the current cell. The user writes
// registers on the cfg_ channel only while no frame is in flight; the block does not
// enforce it. After reset the line store is cleared, one entry a cycle, and in_tready
// stays low; configuration writes are taken meanwhile. Counters, the best side and
// the registers return to their reset values (1024 columns and rows). When the
// receiver stalls, up to two results wait in the output stages and cells keep
// flowing; outside clearing, in_tready drops only when both stages hold a result.
module largest_square_of_ones (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lsq_pkg::IDX_W-1:0] cfg_index,
  input  logic [lsq_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [lsq_pkg::IN_W-1:0]  in_tdata,   // [0] cell_req, [7:1] zero
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [lsq_pkg::OUT_W-1:0] out_tdata   // [10:0] best_side, [31:11] best_area
);
  import lsq_pkg::*;

  `include "largest_square_of_ones_defines.svh"

  logic              res_ready;
  logic              store_busy;
  logic [SIDE_W-1:0] up_raw;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [SIDE_W-1:0] wr_data;
  logic [COL_W-1:0]  rd_addr;
  frame_res_t        frame_res;
  logic [SIDE_W-1:0] out_side;
  logic [AREA_W-1:0] out_area;

  lsq_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (up_raw),
    .busy    (store_busy)
  );

  lsq_cell_core u_cell_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cell_bit   (in_tdata[0]),
    .res_ready  (res_ready),
    .store_busy (store_busy),
    .up_raw     (up_raw),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .frame_res  (frame_res)
  );

  lsq_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_res  (frame_res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign out_side = out_tdata[SIDE_W-1:0];
  assign out_area = out_tdata[OUT_W-1:SIDE_W];

  // Input is held back only by a result backlog or by the clearing pass.
  `LSQ_ASSERT(a_stall_cause, !in_tready |-> (out_tvalid || store_busy), "input stalled without cause")
  `LSQ_ASSERT(a_area_square, out_tvalid |-> (out_area == AREA_W'(out_side) * AREA_W'(out_side)), "area is not the square of the side")
  `LSQ_ASSERT(a_side_range, out_tvalid |-> (out_side <= SIDE_W'(MAX_COLUMNS)), "best side beyond the grid width")
  `LSQ_ASSERT_AFTER_RESET(a_reset_quiet, !out_tvalid && !in_tready, "channels active right after reset")

endmodule
